@@ rtl/lps_pkg.sv @@
// ----------------------------------------------------------------------------
// lps_pkg
// shared constants, record type and ordering helpers for lane priority select
// ----------------------------------------------------------------------------
package lps_pkg;

    localparam int MAX_CANDIDATES = 16;
    localparam int RESULT_LIMIT   = 16;

    localparam int IDX_W  = $clog2(MAX_CANDIDATES);
    localparam int CNT_W  = $clog2(MAX_CANDIDATES + 1);
    localparam int EMIT_W = $clog2(RESULT_LIMIT + 1);

    typedef struct packed {
        logic [31:0] tile;
        logic [31:0] group;
        logic [31:0] lane;
        logic        ramp;
        logic [1:0]  prio;
        logic [7:0]  ord;
    } record_t;

    localparam int REC_W = $bits(record_t);

    typedef struct packed {
        logic             start;
        logic             valid;
        logic [IDX_W-1:0] idx;
    } scan_ctl_t;

    localparam logic [1:0] PRIO_TABLE [2][4] = '{
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd2, 2'd1, 2'd3}
    };

    function automatic logic [1:0] prio_of(input logic dir, input logic [1:0] ttype);
        return PRIO_TABLE[dir][ttype];
    endfunction

    // strict lexicographic order, ord is stored offset so unsigned compare works
    function automatic logic goes_before(input record_t a, input record_t b);
        logic [74:0] ka;
        logic [74:0] kb;
        ka = {a.ramp, a.prio, a.tile, a.group, a.ord};
        kb = {b.ramp, b.prio, b.tile, b.group, b.ord};
        return ka < kb;
    endfunction

endpackage

@@ rtl/lane_priority_select_top.sv @@
// an empty run gives its result in the cycle after the last transfer
// otherwise each selection pass (SCAN, DRAIN, DECIDE) reads every kept record once
// the first result follows two passes, each further result one more pass
// loading takes one item a cycle while busy is low; a run with kept records
// keeps busy high from the last transfer until its last result is emitted
// async reset clears counts and flags; store contents stay undefined until written
// ----------------------------------------------------------------------------
// lane_priority_select_top
// collects lane candidates in a store and emits the best ramp and priority class
// ----------------------------------------------------------------------------
module lane_priority_select_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic [31:0] group_tile,
    input  logic [31:0] group_number,
    input  logic [31:0] lane_number,
    input  logic signed [7:0] lane_position,
    input  logic [1:0]  transition_type,
    input  logic        is_ramp,
    input  logic        lane_found,
    input  logic        last_candidate,
    output logic        strobe,
    output logic [31:0] out_group_tile,
    output logic [31:0] out_group_number,
    output logic [31:0] out_lane_number,
    output logic        none_found,
    output logic        overflow,
    output logic        last_result
);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        DRAIN,
        DECIDE
    } state_t;

    state_t                          state_reg;
    logic                            direction_reg;
    logic [lps_pkg::CNT_W-1:0]       kept_reg;
    logic [lps_pkg::CNT_W-1:0]       kept_next;
    logic                            dropped_reg;
    logic                            dropped_next;
    logic [lps_pkg::MAX_CANDIDATES-1:0] done_reg;
    logic [lps_pkg::IDX_W-1:0]       scan_cnt_reg;
    logic                            pipe_valid_reg;
    logic [lps_pkg::IDX_W-1:0]       pipe_idx_reg;
    logic                            pend_valid_reg;
    lps_pkg::record_t                pend_reg;
    logic [2:0]                      top_reg;
    logic [lps_pkg::EMIT_W-1:0]      emit_cnt_reg;
    logic                            strobe_reg;
    logic [31:0]                     tile_reg;
    logic [31:0]                     group_reg;
    logic [31:0]                     lane_reg;
    logic                            none_reg;
    logic                            ovf_reg;
    logic                            last_reg;

    logic                            accept;
    logic                            wr_en;
    logic                            rd_en;
    lps_pkg::record_t                wr_rec;
    logic [lps_pkg::REC_W-1:0]       rd_data;
    lps_pkg::scan_ctl_t              ctl;
    lps_pkg::record_t                best;
    logic [lps_pkg::IDX_W-1:0]       best_idx;
    logic                            best_found;
    logic                            scan_end;
    logic                            cont;

    assign busy   = (state_reg != IDLE);
    assign accept = start && !busy;
    assign wr_en  = accept && lane_found && (kept_reg < lps_pkg::CNT_W'(lps_pkg::MAX_CANDIDATES));
    assign rd_en  = (state_reg == SCAN);

    assign kept_next    = wr_en ? kept_reg + lps_pkg::CNT_W'(1) : kept_reg;
    assign dropped_next = dropped_reg || (accept && lane_found && !wr_en);

    always_comb
    begin
        wr_rec.tile  = group_tile;
        wr_rec.group = group_number;
        wr_rec.lane  = lane_number;
        wr_rec.ramp  = is_ramp;
        wr_rec.prio  = lps_pkg::prio_of(direction_reg, transition_type);
        wr_rec.ord   = lane_position ^ 8'h80;
    end

    assign ctl.start = (state_reg == DECIDE) || (accept && last_candidate);
    assign ctl.valid = pipe_valid_reg && !done_reg[pipe_idx_reg];
    assign ctl.idx   = pipe_idx_reg;

    assign scan_end = (lps_pkg::CNT_W'(scan_cnt_reg) == kept_reg - lps_pkg::CNT_W'(1));
    assign cont     = best_found && ({best.ramp, best.prio} == top_reg)
                      && ((emit_cnt_reg + lps_pkg::EMIT_W'(1))
                          < lps_pkg::EMIT_W'(lps_pkg::RESULT_LIMIT));

    lps_ram #(
        .WIDTH (lps_pkg::REC_W),
        .DEPTH (lps_pkg::MAX_CANDIDATES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (kept_reg[lps_pkg::IDX_W-1:0]),
        .wr_data (wr_rec),
        .rd_en   (rd_en),
        .rd_addr (scan_cnt_reg),
        .rd_data (rd_data)
    );

    lps_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .rd_data    (rd_data),
        .best       (best),
        .best_idx   (best_idx),
        .best_found (best_found)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            direction_reg  <= 1'b0;
            kept_reg       <= '0;
            dropped_reg    <= 1'b0;
            done_reg       <= '0;
            scan_cnt_reg   <= '0;
            pipe_valid_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            emit_cnt_reg   <= '0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            strobe_reg     <= 1'b0;
            pipe_valid_reg <= 1'b0;
            if (cfg_we)
            begin
                direction_reg <= cfg_wdata;
            end
            unique case (state_reg)
                IDLE:
                begin
                    if (accept)
                    begin
                        kept_reg <= kept_next;
                        if (last_candidate && (kept_next == '0))
                        begin
                            // empty run
                            strobe_reg  <= 1'b1;
                            tile_reg    <= '0;
                            group_reg   <= '0;
                            lane_reg    <= '0;
                            none_reg    <= 1'b1;
                            ovf_reg     <= dropped_next;
                            last_reg    <= 1'b1;
                            dropped_reg <= 1'b0;
                        end
                        else
                        begin
                            dropped_reg <= dropped_next;
                            if (last_candidate)
                            begin
                                state_reg      <= SCAN;
                                done_reg       <= '0;
                                scan_cnt_reg   <= '0;
                                pend_valid_reg <= 1'b0;
                                emit_cnt_reg   <= '0;
                            end
                        end
                    end
                end
                SCAN:
                begin
                    pipe_valid_reg <= 1'b1;
                    pipe_idx_reg   <= scan_cnt_reg;
                    scan_cnt_reg   <= scan_cnt_reg + lps_pkg::IDX_W'(1);
                    if (scan_end)
                    begin
                        state_reg <= DRAIN;
                    end
                end
                DRAIN:
                begin
                    state_reg <= DECIDE;
                end
                DECIDE:
                begin
                    scan_cnt_reg <= '0;
                    if (!pend_valid_reg)
                    begin
                        // first pass fixes the winning class
                        top_reg            <= {best.ramp, best.prio};
                        pend_reg           <= best;
                        pend_valid_reg     <= 1'b1;
                        done_reg[best_idx] <= 1'b1;
                        state_reg          <= SCAN;
                    end
                    else
                    begin
                        strobe_reg   <= 1'b1;
                        tile_reg     <= pend_reg.tile;
                        group_reg    <= pend_reg.group;
                        lane_reg     <= pend_reg.lane;
                        none_reg     <= 1'b0;
                        ovf_reg      <= dropped_reg;
                        last_reg     <= !cont;
                        emit_cnt_reg <= emit_cnt_reg + lps_pkg::EMIT_W'(1);
                        if (cont)
                        begin
                            pend_reg           <= best;
                            done_reg[best_idx] <= 1'b1;
                            state_reg          <= SCAN;
                        end
                        else
                        begin
                            kept_reg       <= '0;
                            dropped_reg    <= 1'b0;
                            pend_valid_reg <= 1'b0;
                            state_reg      <= IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign strobe           = strobe_reg;
    assign out_group_tile   = tile_reg;
    assign out_group_number = group_reg;
    assign out_lane_number  = lane_reg;
    assign none_found       = none_reg;
    assign overflow         = ovf_reg;
    assign last_result      = last_reg;

`ifndef SYNTH
    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && none_found |-> last_result && (out_lane_number == 32'd0))
        else $error("none found result not final or not zeroed");

    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_result |-> busy)
        else $error("non final result while idle");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (lps_pkg::CNT_W'(scan_cnt_reg) < kept_reg))
        else $error("store read beyond kept records");

    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !busy)
        else $error("store written during selection");

    a_emit_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == DECIDE) && pend_valid_reg
        |-> (emit_cnt_reg < lps_pkg::EMIT_W'(lps_pkg::RESULT_LIMIT)))
        else $error("result count beyond limit");
`endif

endmodule

@@ rtl/lps_ram.sv @@
// ----------------------------------------------------------------------------
// lps_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/lps_scan.sv @@
// ----------------------------------------------------------------------------
// lps_scan
// running minimum over records streamed from the store, earliest index wins ties
// ----------------------------------------------------------------------------
module lps_scan (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lps_pkg::scan_ctl_t           ctl,
    input  logic [lps_pkg::REC_W-1:0]    rd_data,
    output lps_pkg::record_t             best,
    output logic [lps_pkg::IDX_W-1:0]    best_idx,
    output logic                         best_found
);

    lps_pkg::record_t             rec;
    lps_pkg::record_t             best_reg;
    logic [lps_pkg::IDX_W-1:0]    idx_reg;
    logic                         found_reg;
    logic                         take;

    assign rec  = lps_pkg::record_t'(rd_data);
    assign take = ctl.valid && (!found_reg || lps_pkg::goes_before(rec, best_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (ctl.start)
        begin
            found_reg <= 1'b0;
        end
        else if (take)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctl.start && take)
        begin
            best_reg <= rec;
            idx_reg  <= ctl.idx;
        end
    end

    assign best       = best_reg;
    assign best_idx   = idx_reg;
    assign best_found = found_reg;

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for lane_priority_select_top: candidate runs are driven
// in random bursts, a predictor rebuilds the sorted best class of every run
// and the monitor checks each emitted lane against it in order
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic DIR_FORWARD  = 1'b0;
    localparam logic DIR_BACKWARD = 1'b1;

    localparam logic [1:0] TT_UNKNOWN   = 2'd0;
    localparam logic [1:0] TT_MERGE     = 2'd1;
    localparam logic [1:0] TT_SPLIT     = 2'd2;
    localparam logic [1:0] TT_UNDEFINED = 2'd3;

    localparam int RUN_MIXED     = 0;
    localparam int RUN_ONE_CLASS = 1;
    localparam int RUN_SPARSE    = 2;
    localparam int RUN_FLOOD     = 3;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 30;
    localparam int PHASE_ITEMS   = 38;

    typedef struct {
        logic [31:0] tile;
        logic [31:0] grp;
        logic [31:0] lane;
        logic [7:0]  order;
        logic [1:0]  ttype;
        logic        ramp;
        logic        found;
        logic        last;
    } candidate_t;

    typedef struct {
        logic [31:0] tile;
        logic [31:0] grp;
        logic [31:0] lane;
        logic        none;
        logic        ovf;
        logic        last;
    } lane_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic [31:0] group_tile = '0;
    logic [31:0] group_number = '0;
    logic [31:0] lane_number = '0;
    logic [7:0]  lane_position = '0;
    logic [1:0]  transition_type = '0;
    logic        is_ramp = 1'b0;
    logic        lane_found = 1'b0;
    logic        last_candidate = 1'b0;
    logic        strobe;
    logic [31:0] out_group_tile;
    logic [31:0] out_group_number;
    logic [31:0] out_lane_number;
    logic        none_found;
    logic        overflow;
    logic        last_result;

    candidate_t   pending_candidates[$];
    lane_result_t expected_lanes[$];
    lane_result_t want_lane;

    // predictor state
    logic [31:0] held_tile [lps_pkg::MAX_CANDIDATES];
    logic [31:0] held_grp  [lps_pkg::MAX_CANDIDATES];
    logic [31:0] held_lane [lps_pkg::MAX_CANDIDATES];
    logic [2:0]  held_cls  [lps_pkg::MAX_CANDIDATES];
    logic [7:0]  held_pos  [lps_pkg::MAX_CANDIDATES];
    int          held_count = 0;
    logic        held_dropped = 1'b0;
    logic        dir_now = DIR_FORWARD;

    int fail_count = 0;
    int items_queued = 0;
    int items_sent = 0;
    int results_seen = 0;
    int runs_closed = 0;
    int none_runs = 0;
    int overflow_runs = 0;
    int full_runs = 0;
    int cycle_count = 0;
    int burst_left = 1;
    int gap_left = 0;

    always #2 clk = ~clk;

    lane_priority_select_top uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .group_tile       (group_tile),
        .group_number     (group_number),
        .lane_number      (lane_number),
        .lane_position    (lane_position),
        .transition_type  (transition_type),
        .is_ramp          (is_ramp),
        .lane_found       (lane_found),
        .last_candidate   (last_candidate),
        .strobe           (strobe),
        .out_group_tile   (out_group_tile),
        .out_group_number (out_group_number),
        .out_lane_number  (out_lane_number),
        .none_found       (none_found),
        .overflow         (overflow),
        .last_result      (last_result)
    );

    function automatic logic [1:0] transition_rank(input logic dir, input logic [1:0] tt);
        case (tt)
            TT_UNKNOWN: return 2'd0;
            TT_MERGE:   return (dir == DIR_BACKWARD) ? 2'd2 : 2'd1;
            TT_SPLIT:   return (dir == DIR_BACKWARD) ? 2'd1 : 2'd2;
            default:    return 2'd3;
        endcase
    endfunction

    function automatic logic [74:0] sort_key(input int i);
        return {held_cls[i], held_tile[i], held_grp[i], held_pos[i]};
    endfunction

    // stores one transfer and, on the closing one, queues the selected lanes
    task automatic load_candidate(input candidate_t c);
        int order_idx [lps_pkg::MAX_CANDIDATES];
        int i;
        int j;
        int sel;
        lane_result_t r;
        if (c.found) begin
            if (held_count < lps_pkg::MAX_CANDIDATES) begin
                held_tile[held_count] = c.tile;
                held_grp[held_count]  = c.grp;
                held_lane[held_count] = c.lane;
                held_cls[held_count]  = {c.ramp, transition_rank(dir_now, c.ttype)};
                held_pos[held_count]  = c.order ^ 8'h80;
                held_count++;
            end
            else begin
                held_dropped = 1'b1;
            end
        end
        if (c.last) begin
            runs_closed++;
            if (held_dropped)
                overflow_runs++;
            if (held_count == 0) begin
                r = '{32'd0, 32'd0, 32'd0, 1'b1, held_dropped, 1'b1};
                expected_lanes = {expected_lanes, r};
                none_runs++;
            end
            else begin
                // stable insertion sort
                for (i = 0; i < held_count; i++) begin
                    j = i;
                    while (j > 0 && sort_key(i) < sort_key(order_idx[j-1])) begin
                        order_idx[j] = order_idx[j-1];
                        j--;
                    end
                    order_idx[j] = i;
                end
                sel = 1;
                while (sel < held_count && sel < lps_pkg::RESULT_LIMIT &&
                       held_cls[order_idx[sel]] == held_cls[order_idx[0]])
                    sel++;
                if (sel == lps_pkg::RESULT_LIMIT)
                    full_runs++;
                for (i = 0; i < sel; i++) begin
                    r.tile = held_tile[order_idx[i]];
                    r.grp  = held_grp[order_idx[i]];
                    r.lane = held_lane[order_idx[i]];
                    r.none = 1'b0;
                    r.ovf  = held_dropped;
                    r.last = (i == sel - 1);
                    expected_lanes = {expected_lanes, r};
                end
            end
            held_count   = 0;
            held_dropped = 1'b0;
        end
    endtask

    // driver: bursts of transfers with random gaps
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            start          <= 1'b0;
            group_tile     <= '0;
            group_number   <= '0;
            lane_number    <= '0;
            lane_position  <= '0;
            transition_type <= TT_UNKNOWN;
            is_ramp        <= 1'b0;
            lane_found     <= 1'b0;
            last_candidate <= 1'b0;
            burst_left = 1;
            gap_left   = 0;
        end
        else begin
            if (start && !busy) begin
                load_candidate(pending_candidates.pop_front());
                items_sent++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else if (!start && gap_left > 0) begin
                gap_left--;
            end
            if (pending_candidates.size() != 0 && gap_left == 0) begin
                start           <= 1'b1;
                group_tile      <= pending_candidates[0].tile;
                group_number    <= pending_candidates[0].grp;
                lane_number     <= pending_candidates[0].lane;
                lane_position   <= pending_candidates[0].order;
                transition_type <= pending_candidates[0].ttype;
                is_ramp         <= pending_candidates[0].ramp;
                lane_found      <= pending_candidates[0].found;
                last_candidate  <= pending_candidates[0].last;
            end
            else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && strobe) begin
            results_seen++;
            if (expected_lanes.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected lane result tile=%h grp=%h lane=%h %s",
                             $time, out_group_tile, out_group_number, out_lane_number,
                             $sformatf("none=%b ovf=%b last=%b",
                                       none_found, overflow, last_result));
            end
            else begin
                want_lane = expected_lanes.pop_front();
                if (out_group_tile !== want_lane.tile || out_group_number !== want_lane.grp ||
                    out_lane_number !== want_lane.lane || none_found !== want_lane.none ||
                    overflow !== want_lane.ovf || last_result !== want_lane.last) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: lane result mismatch", $time);
                        $display("    expected tile=%h grp=%h lane=%h none=%b ovf=%b last=%b",
                                 want_lane.tile, want_lane.grp, want_lane.lane,
                                 want_lane.none, want_lane.ovf, want_lane.last);
                        $display("    actual   tile=%h grp=%h lane=%h none=%b ovf=%b last=%b",
                                 out_group_tile, out_group_number, out_lane_number,
                                 none_found, overflow, last_result);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_lanes.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic queue_candidate(input logic [31:0] tile, input logic [31:0] grp,
                                   input logic [31:0] lane, input logic [7:0] order,
                                   input logic [1:0] tt, input logic ramp,
                                   input logic found, input logic last);
        candidate_t c;
        c = '{tile, grp, lane, order, tt, ramp, found, last};
        pending_candidates = {pending_candidates, c};
        items_queued++;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_order();
        logic [31:0] w;
        w = $urandom;
        case ($urandom_range(0, 4))
            0: return 8'h80;
            1: return 8'h7F;
            2: return {6'b0, w[1:0]};
            default: return w[7:0];
        endcase
    endfunction

    // queues one run of candidates; an open run is closed by the next phase
    task automatic queue_run(input int len, input int style, input bit close);
        int k;
        logic       fixed_ramp;
        logic [1:0] fixed_tt;
        bit         one_class;
        logic       found;
        logic [1:0] tt;
        logic       ramp;
        fixed_ramp = 1'($urandom_range(0, 1));
        fixed_tt   = 2'($urandom_range(0, 3));
        one_class  = (style == RUN_ONE_CLASS) ||
                     (style == RUN_FLOOD && $urandom_range(0, 1) == 1);
        for (k = 0; k < len; k++) begin
            case (style)
                RUN_SPARSE: found = ($urandom_range(0, 2) == 0);
                RUN_MIXED:  found = ($urandom_range(0, 7) != 0);
                default:    found = 1'b1;
            endcase
            tt   = one_class ? fixed_tt : 2'($urandom_range(0, 3));
            ramp = one_class ? fixed_ramp : ($urandom_range(0, 3) == 0);
            if (one_class)
                queue_candidate($urandom_range(0, 2), $urandom_range(0, 2), $urandom,
                                pick_order(), tt, ramp, found, close && k == len - 1);
            else
                queue_candidate(pick_word(), pick_word(), pick_word(), pick_order(),
                                tt, ramp, found, close && k == len - 1);
        end
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_candidates.size() != 0 || start || busy || expected_lanes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_direction(input logic value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        dir_now = value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    initial begin
        int p;
        int style;
        int len;
        int phase_start;
        logic dir_plan [7];
        dir_plan = '{DIR_BACKWARD, DIR_FORWARD, DIR_BACKWARD, DIR_BACKWARD,
                     DIR_FORWARD, DIR_FORWARD, DIR_BACKWARD};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        write_direction(DIR_FORWARD);

        // empty run
        queue_candidate(32'd0, 32'd0, 32'd0, 8'h00, TT_UNKNOWN, 1'b0, 1'b0, 1'b1);
        // every transition type, ramp sorted behind
        queue_candidate(32'd5, 32'd1, 32'd10, 8'h00, TT_SPLIT, 1'b1, 1'b1, 1'b0);
        queue_candidate(32'd5, 32'd1, 32'd11, 8'h00, TT_UNDEFINED, 1'b0, 1'b1, 1'b0);
        queue_candidate(32'd5, 32'd1, 32'd12, 8'h00, TT_MERGE, 1'b0, 1'b1, 1'b0);
        queue_candidate(32'd5, 32'd1, 32'd13, 8'h00, TT_SPLIT, 1'b0, 1'b1, 1'b0);
        queue_candidate(32'd5, 32'd1, 32'd14, 8'h00, TT_UNKNOWN, 1'b1, 1'b1, 1'b1);
        // identical keys keep arrival order
        queue_candidate(32'd7, 32'd7, 32'd20, 8'hFD, TT_MERGE, 1'b0, 1'b1, 1'b0);
        queue_candidate(32'd7, 32'd7, 32'd21, 8'hFD, TT_MERGE, 1'b0, 1'b1, 1'b0);
        queue_candidate(32'd7, 32'd7, 32'd22, 8'hFD, TT_MERGE, 1'b0, 1'b1, 1'b1);
        // field extremes
        queue_candidate(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 8'h7F, TT_UNKNOWN, 1'b0, 1'b1, 1'b0);
        queue_candidate(32'd0, 32'hFFFF_FFFF, 32'd0, 8'h80, TT_UNKNOWN, 1'b0, 1'b1, 1'b0);
        queue_candidate(32'd0, 32'hFFFF_FFFF, 32'd1, 8'h7F, TT_UNKNOWN, 1'b0, 1'b1, 1'b0);
        queue_candidate(32'd0, 32'd0, 32'd2, 8'h80, TT_UNKNOWN, 1'b0, 1'b1, 1'b1);
        // closing candidate not found
        queue_candidate(32'd3, 32'd3, 32'd30, 8'h00, TT_MERGE, 1'b0, 1'b1, 1'b0);
        queue_candidate(32'd3, 32'd3, 32'd31, 8'h00, TT_MERGE, 1'b0, 1'b0, 1'b1);
        // only ramps, undefined transition type
        queue_candidate(32'd9, 32'd9, 32'd40, 8'h05, TT_UNDEFINED, 1'b1, 1'b1, 1'b0);
        queue_candidate(32'd9, 32'd8, 32'd41, 8'h05, TT_UNDEFINED, 1'b1, 1'b1, 1'b1);
        // nothing found
        queue_candidate(32'd1, 32'd1, 32'd50, 8'h00, TT_SPLIT, 1'b0, 1'b0, 1'b0);
        queue_candidate(32'd1, 32'd1, 32'd51, 8'h00, TT_SPLIT, 1'b0, 1'b0, 1'b1);
        // run left open across a direction change
        queue_candidate(32'd2, 32'd0, 32'd60, 8'h00, TT_MERGE, 1'b0, 1'b1, 1'b0);
        wait_idle();
        write_direction(DIR_BACKWARD);
        queue_candidate(32'd1, 32'd0, 32'd61, 8'h00, TT_SPLIT, 1'b0, 1'b1, 1'b1);
        queue_candidate(32'd4, 32'd0, 32'd70, 8'h00, TT_MERGE, 1'b0, 1'b1, 1'b0);
        queue_candidate(32'd4, 32'd0, 32'd71, 8'h00, TT_SPLIT, 1'b0, 1'b1, 1'b1);
        wait_idle();

        for (p = 0; p < 7; p++) begin
            write_direction(dir_plan[p]);
            phase_start = items_queued;
            while (items_queued - phase_start < PHASE_ITEMS) begin
                style = $urandom_range(0, 9);
                if (style == 0) begin
                    queue_run($urandom_range(17, 20), RUN_FLOOD, 1'b1);
                end
                else if (style <= 3) begin
                    len = ($urandom_range(0, 3) == 0) ? lps_pkg::MAX_CANDIDATES
                                                      : $urandom_range(1, 10);
                    queue_run(len, RUN_ONE_CLASS, 1'b1);
                end
                else if (style == 4) begin
                    queue_run($urandom_range(1, 6), RUN_SPARSE, 1'b1);
                end
                else begin
                    queue_run($urandom_range(1, 8), RUN_MIXED, 1'b1);
                end
            end
            if (p < 6 && $urandom_range(0, 1) == 1)
                queue_run($urandom_range(1, 3), RUN_MIXED, 1'b0);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        $display("covered %0d transfers in %0d runs, %0d lane results checked",
                 items_sent, runs_closed, results_seen);
        $display("runs with none found %0d, with overflow %0d, at the result limit %0d",
                 none_runs, overflow_runs, full_runs);
        if (fail_count == 0 && expected_lanes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
